// ===== hw/rtl/ctfp_pkg.sv =====
package ctfp_pkg;

    // frame syntax
    localparam logic [7:0] SEP_CHAR           = 8'h23;  // '#'
    localparam int         MAX_ID_DIGITS      = 3;
    localparam int         MAX_PAYLOAD_DIGITS = 16;
    localparam int         PAYLOAD_BYTES      = 8;

    // saturation points of the digit counters
    localparam logic [2:0] ID_SAT  = 3'd4;
    localparam logic [4:0] PAY_SAT = 5'd17;

    localparam int DATA_W = 8;
    localparam int ID_W   = 12;
    localparam int CNT_W  = 4;
    localparam int OUT_W  = ID_W + CNT_W + PAYLOAD_BYTES * DATA_W;

    // character classification
    typedef struct packed {
        logic       is_hex;
        logic       is_sep;
        logic [3:0] nibble;
    } char_class_t;

endpackage

// ===== hw/rtl/ctfp_char_decode.sv =====
module ctfp_char_decode
    import ctfp_pkg::*;
(
    input  logic [7:0]  ch,
    output char_class_t cls
);

    logic is_digit;
    logic is_upper;
    logic is_lower;

    always_comb begin
        is_digit = (ch >= 8'h30) && (ch <= 8'h39);
        is_upper = (ch >= 8'h41) && (ch <= 8'h46);
        is_lower = (ch >= 8'h61) && (ch <= 8'h66);
        cls.is_hex = is_digit || is_upper || is_lower;
        cls.is_sep = (ch == SEP_CHAR);
        // letters a-f / A-F carry 1..6 in the low nibble
        cls.nibble = is_digit ? ch[3:0] : (ch[3:0] + 4'd9);
    end

endmodule

// ===== hw/rtl/can_text_frame_parser_core.sv =====
// result: a result is on m_tvalid in the cycle after the accepted last character
// throughput: one character per cycle while the result register drains
// characters without tlast update frame state only and produce no item
// reset: aresetn is synchronous and active low; it clears the frame state
// and drops m_tvalid, the result payload register is not reset
module can_text_frame_parser_core
    import ctfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    // character stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // ch[7:0]
    input  logic              s_tlast,   // last_char

    // parsed frame stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // frame_id[11:0], byte_count[15:12],
                                         // data_0[23:16] .. data_7[79:72]
    output logic              m_tuser    // frame_ok
);

    // frame state
    logic                    in_payload_reg, in_payload_next;
    logic [ID_W-1:0]         id_value_reg, id_value_next;
    logic [2:0]              id_cnt_reg, id_cnt_next;
    logic [4:0]              pay_cnt_reg, pay_cnt_next;
    logic [DATA_W-1:0]       store_reg [PAYLOAD_BYTES];
    logic [DATA_W-1:0]       store_next [PAYLOAD_BYTES];
    logic                    bad_reg, bad_next;

    // result register
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]        m_data_reg, m_data_next;
    logic                    m_ok_reg, m_ok_next;

    logic                    accept;
    logic                    frame_ok;
    logic [2:0]              wr_idx;
    char_class_t             cls;

    ctfp_char_decode u_decode (
        .ch  (s_tdata),
        .cls (cls)
    );

    // output register frees up whenever the downstream side takes the item
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign wr_idx   = pay_cnt_reg[3:1];

    // per-character update of the frame state
    always_comb begin
        in_payload_next = in_payload_reg;
        id_value_next   = id_value_reg;
        id_cnt_next     = id_cnt_reg;
        pay_cnt_next    = pay_cnt_reg;
        bad_next        = bad_reg;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            store_next[i] = store_reg[i];
        end

        if (!in_payload_reg) begin
            // identifier part, first '#' switches to payload
            priority if (cls.is_sep) begin
                in_payload_next = 1'b1;
            end else if (!cls.is_hex) begin
                bad_next = 1'b1;
            end else begin
                id_value_next = {id_value_reg[ID_W-5:0], cls.nibble};
                if (id_cnt_reg < ID_SAT) begin
                    id_cnt_next = id_cnt_reg + 3'd1;
                end
            end
        end else begin
            if (!cls.is_hex) begin
                bad_next = 1'b1;
            end else begin
                // two digits per byte, high nibble first; digits past the store are dropped
                if (!pay_cnt_reg[4]) begin
                    store_next[wr_idx] = {store_reg[wr_idx][3:0], cls.nibble};
                end
                if (pay_cnt_reg < PAY_SAT) begin
                    pay_cnt_next = pay_cnt_reg + 5'd1;
                end
            end
        end
    end

    // frame check on the state after the last character
    always_comb begin
        frame_ok = !bad_next && in_payload_next
                   && (id_cnt_next >= 3'd1)
                   && (id_cnt_next <= 3'(MAX_ID_DIGITS))
                   && !pay_cnt_next[0]
                   && (pay_cnt_next <= 5'(MAX_PAYLOAD_DIGITS));
    end

    // result assembly; bytes beyond the count were never written and stay zero
    always_comb begin
        m_ok_next   = frame_ok;
        m_data_next = '0;
        if (frame_ok) begin
            m_data_next[ID_W-1:0]         = id_value_next;
            m_data_next[ID_W+CNT_W-1:ID_W] = pay_cnt_next[4:1];
            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                m_data_next[ID_W+CNT_W+i*DATA_W +: DATA_W] = store_next[i];
            end
        end
        m_valid_next = m_valid_reg && !m_tready;
        if (accept && s_tlast) begin
            m_valid_next = 1'b1;
        end
    end

    // frame state registers, cleared after every last character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg <= 1'b0;
            id_value_reg   <= '0;
            id_cnt_reg     <= '0;
            pay_cnt_reg    <= '0;
            bad_reg        <= 1'b0;
            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                store_reg[i] <= '0;
            end
        end else if (accept) begin
            if (s_tlast) begin
                in_payload_reg <= 1'b0;
                id_value_reg   <= '0;
                id_cnt_reg     <= '0;
                pay_cnt_reg    <= '0;
                bad_reg        <= 1'b0;
                for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                    store_reg[i] <= '0;
                end
            end else begin
                in_payload_reg <= in_payload_next;
                id_value_reg   <= id_value_next;
                id_cnt_reg     <= id_cnt_next;
                pay_cnt_reg    <= pay_cnt_next;
                bad_reg        <= bad_next;
                for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                    store_reg[i] <= store_next[i];
                end
            end
        end
    end

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, loaded only when a frame ends
    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            m_data_reg <= m_data_next;
            m_ok_reg   <= m_ok_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_ok_reg;

    // a last character always produces a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> m_tvalid)
        else $error("no result after last character");

    // frame state is empty after a frame ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (!in_payload_reg && !bad_reg
                                 && id_cnt_reg == 3'd0 && pay_cnt_reg == 5'd0))
        else $error("frame state not cleared");

    // an invalid frame carries an all-zero payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("invalid frame with nonzero payload");

    // a valid frame never reports more than eight bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[ID_W+CNT_W-1:ID_W] <= 4'(PAYLOAD_BYTES)))
        else $error("byte count out of range");

endmodule
